// File: rtl/placement_swap_evaluator_top_defines.svh
// Assertion macros used by the checker file.
`ifndef PLACEMENT_SWAP_EVALUATOR_TOP_DEFINES_SVH
`define PLACEMENT_SWAP_EVALUATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSE_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSE_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pse_pkg.sv
`timescale 1ns / 1ps

package pse_pkg;

    localparam int MAX_GRID_SIDE = 16;
    localparam int MAX_NODES     = 256;
    localparam int MAX_DEGREE    = 8;

    localparam int CELL_W  = 8;
    localparam int NODE_W  = 8;
    localparam int SLOT_W  = 3;
    localparam int LIMIT_W = 9;
    localparam int COST_W  = 9;
    localparam int SIDE_W  = 5;
    localparam int ENTRY_W = NODE_W + 1;

    // Fixed-point scale of the cell-index reciprocal.
    localparam int RECIP_K = 16;

    localparam logic [SIDE_W-1:0] GRID_SIDE_RESET = 5'd16;
    localparam logic [COST_W-1:0] COST_MAX        = '1;

    localparam logic [1:0] CMD_NBR   = 2'd0;
    localparam logic [1:0] CMD_PLACE = 2'd1;
    localparam logic [1:0] CMD_SWAP  = 2'd2;

    localparam logic [1:0] STATUS_LOAD = 2'd0;
    localparam logic [1:0] STATUS_EVAL = 2'd1;
    localparam logic [1:0] STATUS_SKIP = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [NODE_W-1:0]  node_id;
        logic [SLOT_W-1:0]  slot;
        logic [NODE_W-1:0]  neighbor_id;
        logic               slot_used;
        logic [CELL_W-1:0]  cell_a;
        logic [CELL_W-1:0]  cell_b;
        logic [LIMIT_W-1:0] accept_limit;
    } item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              accepted;
        logic [COST_W-1:0] cost_before;
        logic [COST_W-1:0] cost_after;
    } result_t;

    function automatic logic [CELL_W-1:0] absdiff(input logic [CELL_W-1:0] a,
                                                  input logic [CELL_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// File: rtl/placement_swap_evaluator_top.sv
`timescale 1ns / 1ps

// Swap evaluator of an annealing placer on a square grid.
// Command channel: an item beat is taken when start is high and busy is low.
// Commands: write a neighbor slot, place a node on a cell, or propose a swap.
// Each command gives one result beat on result, marked by done for one cycle.
// The receiver cannot stall; results are always taken.
// Load commands and unknown commands answer in the cycle after the beat and
// leave busy low, so one load per cycle is sustained.
// A swap reads both occupants, then walks 2*MaxDegree neighbor slots, one a
// cycle, each through a neighbor-table read, a location read and a two-stage
// row/column split. The result follows the drain of that pipeline and the
// cost compare; an accepted swap first writes both maps back. A swap with a
// cell out of range answers next cycle, and a swap of two empty cells answers
// once both occupants are read. The single read port of each memory sets the
// walk rate.
// After reset the block sweeps the cell and neighbor memories to empty,
// holding busy high until the larger of the two has been swept. The grid
// side register is written on its own channel, always ready; write it only
// while no swap is in progress.
module placement_swap_evaluator_top #(
    parameter int MaxGridSide = pse_pkg::MAX_GRID_SIDE,
    parameter int MaxNodes    = pse_pkg::MAX_NODES,
    parameter int MaxDegree   = pse_pkg::MAX_DEGREE
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  pse_pkg::item_t             item,
    output logic                       busy,
    output logic                       done,
    output pse_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [pse_pkg::SIDE_W-1:0] cfg_data
);

    localparam int NumCells = MaxGridSide * MaxGridSide;
    localparam int OccAw    = $clog2(NumCells);
    localparam int NodeAw   = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
    localparam int DegAw    = (MaxDegree > 1) ? $clog2(MaxDegree) : 1;
    localparam int NbrAw    = NodeAw + DegAw;
    localparam int NbrDepth = MaxNodes * (2 ** DegAw);
    localparam int ClrCount = (NumCells > NbrDepth) ? NumCells : NbrDepth;
    localparam int ClrW     = $clog2(ClrCount);
    localparam int SideW    = $clog2(MaxGridSide + 1);
    localparam int AccW     = $clog2(4 * MaxDegree * (2 ** pse_pkg::CELL_W) + 1);
    localparam int CW       = pse_pkg::CELL_W;
    localparam int EW       = pse_pkg::ENTRY_W;
    localparam int NW       = pse_pkg::NODE_W;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_OCC_A    = 9'b000000100,
        ST_OCC_B    = 9'b000001000,
        ST_WALK     = 9'b000010000,
        ST_DRAIN    = 9'b000100000,
        ST_DECIDE   = 9'b001000000,
        ST_COMMIT_A = 9'b010000000,
        ST_COMMIT_B = 9'b100000000
    } state_t;

    // Reciprocal table, indexed by the effective grid side.
    logic [pse_pkg::RECIP_K:0] recip_tbl [MaxGridSide + 1];

    for (genvar g = 0; g <= MaxGridSide; g++)
    begin : g_recip
        if (g == 0)
        begin : g_zero
            assign recip_tbl[g] = '0;
        end
        else
        begin : g_val
            localparam int R = ((2 ** pse_pkg::RECIP_K) + g - 1) / g;
            assign recip_tbl[g] = (pse_pkg::RECIP_K + 1)'(R);
        end
    end

    state_t state_reg, state_next;
    logic [pse_pkg::SIDE_W-1:0] grid_side_reg;
    logic [ClrW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]     ca_reg, ca_next, cb_reg, cb_next;
    logic [pse_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [EW-1:0]     oa_reg, oa_next, ob_reg, ob_next;
    logic [DegAw-1:0]  slot_reg, slot_next;
    logic              sel_reg, sel_next;
    logic [1:0]        drain_reg, drain_next;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic              s1_reg, s2_reg, s3_reg, s4_reg;
    logic              inr2_reg;
    logic [CW-1:0]     p3_reg, p4_reg;
    logic [AccW-1:0]   bef_reg, bef_next, aft_reg, aft_next;
    pse_pkg::result_t  result_reg, result_next;
    logic              done_reg, done_next;

    logic [SideW-1:0]  side_eff;
    logic [pse_pkg::RECIP_K:0] recip;
    logic              accept;
    logic              ok_a, ok_b, walk_ok;
    logic [CW-1:0]     p2;

    logic              occ_we, nloc_we, nbr_we;
    logic [OccAw-1:0]  occ_waddr, occ_raddr;
    logic [EW-1:0]     occ_wdata, occ_q;
    logic [NodeAw-1:0] nloc_waddr, nloc_raddr;
    logic [CW-1:0]     nloc_wdata, nloc_q;
    logic [NbrAw-1:0]  nbr_waddr, nbr_raddr;
    logic [EW-1:0]     nbr_wdata, nbr_q;

    logic [CW-1:0]     ra, ka, rb, kb, rp, kp;
    logic [CW-1:0]     here_r, here_k, there_r, there_k, there_cell;
    logic [CW:0]       d_ab, d_before, d_other;
    logic [pse_pkg::COST_W-1:0] cbef, caft;
    logic              swap_ok;

    // Effective grid side, clamped to the supported range.
    always_comb
    begin
        if (grid_side_reg < 5'd2)
        begin
            side_eff = SideW'(2);
        end
        else if (32'(grid_side_reg) > MaxGridSide)
        begin
            side_eff = SideW'(MaxGridSide);
        end
        else
        begin
            side_eff = SideW'(grid_side_reg);
        end
    end

    assign recip     = recip_tbl[side_eff];
    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && (state_reg == ST_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;

    assign ok_a    = oa_reg[NW] && (32'(oa_reg[NW-1:0]) < MaxNodes);
    assign ok_b    = ob_reg[NW] && (32'(ob_reg[NW-1:0]) < MaxNodes);
    assign walk_ok = sel_reg ? ok_b : ok_a;

    pse_ram #(.Width(EW), .Depth(NumCells)) u_occ (
        .clk(clk), .we(occ_we), .waddr(occ_waddr), .wdata(occ_wdata),
        .raddr(occ_raddr), .rdata(occ_q)
    );

    pse_ram #(.Width(CW), .Depth(MaxNodes)) u_nloc (
        .clk(clk), .we(nloc_we), .waddr(nloc_waddr), .wdata(nloc_wdata),
        .raddr(nloc_raddr), .rdata(nloc_q)
    );

    pse_ram #(.Width(EW), .Depth(NbrDepth)) u_nbr (
        .clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
        .raddr(nbr_raddr), .rdata(nbr_q)
    );

    pse_divmod #(.SideW(SideW)) u_dm_a (
        .clk(clk), .cell_idx(ca_reg), .side(side_eff), .recip(recip), .row(ra), .col(ka)
    );

    pse_divmod #(.SideW(SideW)) u_dm_b (
        .clk(clk), .cell_idx(cb_reg), .side(side_eff), .recip(recip), .row(rb), .col(kb)
    );

    pse_divmod #(.SideW(SideW)) u_dm_p (
        .clk(clk), .cell_idx(p2), .side(side_eff), .recip(recip), .row(rp), .col(kp)
    );

    // Read addresses of the occupant reads and of the walk pipeline.
    assign occ_raddr  = (state_reg == ST_IDLE) ? OccAw'(item.cell_a) : OccAw'(cb_reg);
    assign nbr_raddr  = {NodeAw'(sel_reg ? ob_reg[NW-1:0] : oa_reg[NW-1:0]), slot_reg};
    assign nloc_raddr = NodeAw'(nbr_q[NW-1:0]);
    assign p2         = inr2_reg ? nloc_q : '0;

    // Distance terms of the stage that leaves the row/column split.
    assign here_r     = s4_reg ? rb : ra;
    assign here_k     = s4_reg ? kb : ka;
    assign there_r    = s4_reg ? ra : rb;
    assign there_k    = s4_reg ? ka : kb;
    assign there_cell = s4_reg ? ca_reg : cb_reg;
    assign d_ab       = (CW+1)'(pse_pkg::absdiff(ra, rb)) + (CW+1)'(pse_pkg::absdiff(ka, kb));
    assign d_before   = (CW+1)'(pse_pkg::absdiff(here_r, rp))
                      + (CW+1)'(pse_pkg::absdiff(here_k, kp));
    assign d_other    = (CW+1)'(pse_pkg::absdiff(there_r, rp))
                      + (CW+1)'(pse_pkg::absdiff(there_k, kp));

    assign cbef    = (bef_reg > AccW'(pse_pkg::COST_MAX)) ? pse_pkg::COST_MAX
                                                          : pse_pkg::COST_W'(bef_reg);
    assign caft    = (aft_reg > AccW'(pse_pkg::COST_MAX)) ? pse_pkg::COST_MAX
                                                          : pse_pkg::COST_W'(aft_reg);
    assign swap_ok = ({1'b0, caft} <= ({1'b0, cbef} + {1'b0, limit_reg}));

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        limit_next   = limit_reg;
        oa_next      = oa_reg;
        ob_next      = ob_reg;
        slot_next    = slot_reg;
        sel_next     = sel_reg;
        drain_next   = drain_reg;
        bef_next     = bef_reg;
        aft_next     = aft_reg;
        result_next  = result_reg;
        done_next    = 1'b0;

        occ_we     = 1'b0;
        occ_waddr  = OccAw'(clr_cnt_reg);
        occ_wdata  = '0;
        nloc_we    = 1'b0;
        nloc_waddr = NodeAw'(item.node_id);
        nloc_wdata = item.cell_a;
        nbr_we     = 1'b0;
        nbr_waddr  = NbrAw'(clr_cnt_reg);
        nbr_wdata  = '0;

        if (v4_reg)
        begin
            bef_next = bef_reg + AccW'(d_before);
            aft_next = aft_reg + ((p4_reg == there_cell) ? AccW'(d_ab) : AccW'(d_other));
        end

        case (state_reg)
            ST_CLEAR:
            begin
                occ_we       = (32'(clr_cnt_reg) < NumCells);
                nbr_we       = (32'(clr_cnt_reg) < NbrDepth);
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ClrW'(ClrCount - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    ca_next     = item.cell_a;
                    cb_next     = item.cell_b;
                    limit_next  = item.accept_limit;
                    result_next = '0;
                    case (item.cmd)
                        pse_pkg::CMD_NBR:
                        begin
                            nbr_waddr = {NodeAw'(item.node_id), DegAw'(item.slot)};
                            nbr_wdata = item.slot_used ? {1'b1, item.neighbor_id} : '0;
                            nbr_we    = (32'(item.node_id) < MaxNodes)
                                     && (32'(item.slot) < MaxDegree);
                            done_next = 1'b1;
                        end
                        pse_pkg::CMD_PLACE:
                        begin
                            occ_waddr = OccAw'(item.cell_a);
                            occ_wdata = {1'b1, item.node_id};
                            occ_we    = (32'(item.node_id) < MaxNodes)
                                     && (32'(item.cell_a) < NumCells);
                            nloc_we   = occ_we;
                            done_next = 1'b1;
                        end
                        pse_pkg::CMD_SWAP:
                        begin
                            if ((32'(item.cell_a) < NumCells) && (32'(item.cell_b) < NumCells))
                            begin
                                state_next = ST_OCC_A;
                            end
                            else
                            begin
                                result_next.status = pse_pkg::STATUS_SKIP;
                                done_next          = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_OCC_A:
            begin
                oa_next    = occ_q;
                state_next = ST_OCC_B;
            end
            ST_OCC_B:
            begin
                ob_next   = occ_q;
                slot_next = '0;
                sel_next  = 1'b0;
                bef_next  = '0;
                aft_next  = '0;
                if (!oa_reg[NW] && !occ_q[NW])
                begin
                    result_next.status = pse_pkg::STATUS_SKIP;
                    done_next          = 1'b1;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                slot_next = slot_reg + 1'b1;
                if (32'(slot_reg) == MaxDegree - 1)
                begin
                    slot_next = '0;
                    sel_next  = 1'b1;
                    if (sel_reg)
                    begin
                        drain_next = '0;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd3)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                result_next.status      = pse_pkg::STATUS_EVAL;
                result_next.accepted    = swap_ok;
                result_next.cost_before = cbef;
                result_next.cost_after  = caft;
                if (swap_ok)
                begin
                    state_next = ST_COMMIT_A;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_COMMIT_A:
            begin
                occ_we     = 1'b1;
                occ_waddr  = OccAw'(ca_reg);
                occ_wdata  = ob_reg;
                nloc_we    = ok_a;
                nloc_waddr = NodeAw'(oa_reg[NW-1:0]);
                nloc_wdata = cb_reg;
                state_next = ST_COMMIT_B;
            end
            ST_COMMIT_B:
            begin
                occ_we     = 1'b1;
                occ_waddr  = OccAw'(cb_reg);
                occ_wdata  = oa_reg;
                nloc_we    = ok_b;
                nloc_waddr = NodeAw'(ob_reg[NW-1:0]);
                nloc_wdata = ca_reg;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            grid_side_reg <= pse_pkg::GRID_SIDE_RESET;
            done_reg      <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                grid_side_reg <= cfg_data;
            end
            v1_reg <= (state_reg == ST_WALK) && walk_ok;
            v2_reg <= v1_reg && nbr_q[NW];
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg     <= ca_next;
        cb_reg     <= cb_next;
        limit_reg  <= limit_next;
        oa_reg     <= oa_next;
        ob_reg     <= ob_next;
        slot_reg   <= slot_next;
        sel_reg    <= sel_next;
        drain_reg  <= drain_next;
        bef_reg    <= bef_next;
        aft_reg    <= aft_next;
        result_reg <= result_next;
        s1_reg     <= sel_reg;
        s2_reg     <= s1_reg;
        s3_reg     <= s2_reg;
        s4_reg     <= s3_reg;
        inr2_reg   <= (32'(nbr_q[NW-1:0]) < MaxNodes);
        p3_reg     <= p2;
        p4_reg     <= p3_reg;
    end

endmodule

// File: rtl/pse_ram.sv
`timescale 1ns / 1ps

module pse_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pse_divmod.sv
`timescale 1ns / 1ps

// Splits a cell index into row and column with a reciprocal multiply.
// The rounded-up reciprocal gives the exact quotient for every index
// below 256 and every side up to 64, so no correction step is needed.
module pse_divmod #(
    parameter int SideW = 5
) (
    input  logic                        clk,
    input  logic [pse_pkg::CELL_W-1:0]  cell_idx,
    input  logic [SideW-1:0]            side,
    input  logic [pse_pkg::RECIP_K:0]   recip,
    output logic [pse_pkg::CELL_W-1:0]  row,
    output logic [pse_pkg::CELL_W-1:0]  col
);

    localparam int ProdW = pse_pkg::CELL_W + pse_pkg::RECIP_K + 1;

    logic [ProdW-1:0]           prod_reg;
    logic [pse_pkg::CELL_W-1:0] cell_reg;
    logic [pse_pkg::CELL_W-1:0] quot;
    logic [pse_pkg::CELL_W-1:0] row_reg;
    logic [pse_pkg::CELL_W-1:0] col_reg;
    logic [pse_pkg::CELL_W+SideW-1:0] back;

    assign quot = prod_reg[pse_pkg::RECIP_K +: pse_pkg::CELL_W];
    assign back = quot * side;

    always_ff @(posedge clk)
    begin
        prod_reg <= ProdW'(cell_idx) * ProdW'(recip);
        cell_reg <= cell_idx;
        row_reg  <= quot;
        col_reg  <= cell_reg - back[pse_pkg::CELL_W-1:0];
    end

    assign row = row_reg;
    assign col = col_reg;

endmodule

// File: rtl/pse_checker.sv
`timescale 1ns / 1ps
`include "placement_swap_evaluator_top_defines.svh"

module pse_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input pse_pkg::item_t   item,
    input pse_pkg::result_t result
);

    `PSE_CHECK_NEXT(a_load_next, start && !busy && (item.cmd != pse_pkg::CMD_SWAP), done && (result.status == pse_pkg::STATUS_LOAD), "load beat not answered next cycle")
    `PSE_CHECK_NEXT(a_swap_runs, start && !busy && (item.cmd == pse_pkg::CMD_SWAP), busy || done, "swap beat neither running nor answered")
    `PSE_CHECK(a_quiet_fields, done && (result.status != pse_pkg::STATUS_EVAL), !result.accepted && (result.cost_before == '0) && (result.cost_after == '0), "non-evaluated result carries data")
    `PSE_CHECK(a_drop_taken, done && (result.status == pse_pkg::STATUS_EVAL) && (result.cost_after <= result.cost_before), result.accepted, "cost drop not accepted")

endmodule

bind placement_swap_evaluator_top pse_checker u_pse_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .item(item),
    .result(result)
);

// File: test/placement_swap_evaluator_top_test.sv
`timescale 1ns / 1ps

module placement_swap_evaluator_top_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;

    typedef struct {
        pse_pkg::item_t   it;
        bit               typed;
        pse_pkg::result_t res;
    } vector_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    pse_pkg::item_t   item = '0;
    logic             busy;
    logic             done;
    pse_pkg::result_t result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [pse_pkg::SIDE_W-1:0] cfg_data = '0;

    // Shadow copy of the block's maps and register.
    logic [pse_pkg::CELL_W-1:0]  node_cell [pse_pkg::MAX_NODES];
    logic [pse_pkg::ENTRY_W-1:0] cell_node [pse_pkg::MAX_GRID_SIDE*pse_pkg::MAX_GRID_SIDE];
    logic [pse_pkg::ENTRY_W-1:0] adjacency [pse_pkg::MAX_NODES*pse_pkg::MAX_DEGREE];
    logic [pse_pkg::SIDE_W-1:0]  grid_side;

    pse_pkg::result_t pending_results[$];
    int      placed_nodes[$];
    bit      is_placed [pse_pkg::MAX_NODES];
    int      cycles;
    int      mismatches;
    int      n_results, n_accepted, n_rejected, n_skipped, n_loads;

    placement_swap_evaluator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int wire_length(int p, int q, int side);
        int dr;
        int dc;
        dr = p / side - q / side;
        dc = p % side - q % side;
        if (dr < 0) dr = -dr;
        if (dc < 0) dc = -dc;
        return dr + dc;
    endfunction

    // Adds the neighbor wirelength of node n when it moves from here to there.
    function automatic void node_wirelength(int n, int here, int there, int side,
                                            inout int bef, inout int aft);
        logic [pse_pkg::ENTRY_W-1:0] e;
        int p;
        for (int k = 0; k < pse_pkg::MAX_DEGREE; k++)
        begin
            e = adjacency[n*pse_pkg::MAX_DEGREE + k];
            if (e[pse_pkg::NODE_W])
            begin
                p = node_cell[e[pse_pkg::NODE_W-1:0]];
                bef += wire_length(here, p, side);
                if (p == there)
                    aft += wire_length(here, there, side);
                else
                    aft += wire_length(there, p, side);
            end
        end
    endfunction

    function automatic pse_pkg::result_t evaluate_command(pse_pkg::item_t it);
        pse_pkg::result_t r;
        logic [pse_pkg::ENTRY_W-1:0] oa;
        logic [pse_pkg::ENTRY_W-1:0] ob;
        int side;
        int bef;
        int aft;
        r = '0;
        r.status = pse_pkg::STATUS_LOAD;
        case (it.cmd)
            pse_pkg::CMD_NBR:
                adjacency[it.node_id*pse_pkg::MAX_DEGREE + it.slot] =
                    it.slot_used ? {1'b1, it.neighbor_id} : '0;
            pse_pkg::CMD_PLACE:
            begin
                node_cell[it.node_id] = it.cell_a;
                cell_node[it.cell_a]  = {1'b1, it.node_id};
            end
            pse_pkg::CMD_SWAP:
            begin
                r.status = pse_pkg::STATUS_SKIP;
                oa = cell_node[it.cell_a];
                ob = cell_node[it.cell_b];
                if (oa[pse_pkg::NODE_W] || ob[pse_pkg::NODE_W])
                begin
                    side = grid_side < 2 ? 2 : grid_side > pse_pkg::MAX_GRID_SIDE ?
                           pse_pkg::MAX_GRID_SIDE : int'(grid_side);
                    bef = 0;
                    aft = 0;
                    if (oa[pse_pkg::NODE_W])
                        node_wirelength(oa[pse_pkg::NODE_W-1:0], it.cell_a, it.cell_b,
                                        side, bef, aft);
                    if (ob[pse_pkg::NODE_W])
                        node_wirelength(ob[pse_pkg::NODE_W-1:0], it.cell_b, it.cell_a,
                                        side, bef, aft);
                    if (bef > pse_pkg::COST_MAX) bef = pse_pkg::COST_MAX;
                    if (aft > pse_pkg::COST_MAX) aft = pse_pkg::COST_MAX;
                    r.status      = pse_pkg::STATUS_EVAL;
                    r.cost_before = bef;
                    r.cost_after  = aft;
                    if (aft < bef || aft - bef <= it.accept_limit)
                    begin
                        r.accepted = 1'b1;
                        if (oa[pse_pkg::NODE_W]) node_cell[oa[pse_pkg::NODE_W-1:0]] = it.cell_b;
                        if (ob[pse_pkg::NODE_W]) node_cell[ob[pse_pkg::NODE_W-1:0]] = it.cell_a;
                        cell_node[it.cell_a] = ob;
                        cell_node[it.cell_b] = oa;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Holds the beat until the block takes it; the next beat may follow at once.
    task automatic issue(pse_pkg::item_t it, bit typed, pse_pkg::result_t typed_res);
        pse_pkg::result_t r;
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        r = evaluate_command(it);
        pending_results.push_back(typed ? typed_res : r);
        if (it.cmd == pse_pkg::CMD_PLACE && !is_placed[it.node_id])
        begin
            is_placed[it.node_id] = 1'b1;
            placed_nodes.push_back(it.node_id);
        end
    endtask

    task automatic idle_gap();
        int g;
        int sel;
        sel = $urandom_range(0, 99);
        g = sel < 55 ? 0 : sel < 90 ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (g > 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_grid_side(logic [pse_pkg::SIDE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        grid_side = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic pse_pkg::item_t random_command();
        pse_pkg::item_t it;
        int sel;
        it = pse_pkg::item_t'({$urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            it.cmd = pse_pkg::CMD_NBR;
            if (it.slot_used)
                it.neighbor_id = placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
        end
        else if (sel < 52)
            it.cmd = pse_pkg::CMD_PLACE;
        else if (sel < 96)
        begin
            it.cmd = pse_pkg::CMD_SWAP;
            // Mostly aim at occupied cells so that swaps get evaluated.
            if ($urandom_range(0, 9) < 7)
                it.cell_a = node_cell[placed_nodes[$urandom_range(0, placed_nodes.size()-1)]];
            if ($urandom_range(0, 9) < 6)
                it.cell_b = node_cell[placed_nodes[$urandom_range(0, placed_nodes.size()-1)]];
            if ($urandom_range(0, 3) == 0)
                it.accept_limit = $urandom_range(0, 8);
        end
        else
            it.cmd = 2'd3;
        return it;
    endfunction

    function automatic pse_pkg::item_t mk(logic [1:0] c, int node, int slot, int nbr, bit used,
                                          int ca, int cb, int lim);
        pse_pkg::item_t it;
        it.cmd          = c;
        it.node_id      = node;
        it.slot         = slot;
        it.neighbor_id  = nbr;
        it.slot_used    = used;
        it.cell_a       = ca;
        it.cell_b       = cb;
        it.accept_limit = lim;
        return it;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat %p", result);
            end
            else
            begin
                pse_pkg::result_t e;
                e = pending_results.pop_front();
                if (result.status !== e.status || result.accepted !== e.accepted ||
                    result.cost_before !== e.cost_before ||
                    result.cost_after !== e.cost_after)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", e, result);
                end
                case (e.status)
                    pse_pkg::STATUS_EVAL: if (e.accepted) n_accepted++; else n_rejected++;
                    pse_pkg::STATUS_SKIP: n_skipped++;
                    default:              n_loads++;
                endcase
            end
        end
    end

    initial
    begin
        vector_t vectors[$];
        logic [pse_pkg::SIDE_W-1:0] sides[6];
        pse_pkg::result_t none;
        pse_pkg::result_t skipped;
        cycles = 0;
        mismatches = 0;
        for (int i = 0; i < pse_pkg::MAX_NODES; i++)
        begin
            node_cell[i] = '0;
            cell_node[i] = '0;
            is_placed[i] = 1'b0;
        end
        for (int i = 0; i < pse_pkg::MAX_NODES*pse_pkg::MAX_DEGREE; i++)
            adjacency[i] = '0;
        grid_side = pse_pkg::GRID_SIDE_RESET;
        none = '0;
        skipped = '0;
        skipped.status = pse_pkg::STATUS_SKIP;

        vectors = '{
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 0, 255, 511),   1, skipped},
            '{mk(2'd3,             255, 7, 255, 1, 255, 255, 511), 1, none},
            '{mk(pse_pkg::CMD_PLACE, 0, 0, 0, 0, 0, 0, 0),       1, none},
            '{mk(pse_pkg::CMD_PLACE, 255, 7, 255, 1, 255, 0, 0), 1, none},
            '{mk(pse_pkg::CMD_PLACE, 1, 0, 0, 0, 17, 0, 0),      1, none},
            '{mk(pse_pkg::CMD_NBR,   0, 0, 255, 1, 0, 0, 0),     1, none},
            '{mk(pse_pkg::CMD_NBR,   0, 7, 1, 1, 0, 0, 0),       1, none},
            '{mk(pse_pkg::CMD_NBR,   255, 3, 0, 1, 0, 0, 0),     1, none},
            '{mk(pse_pkg::CMD_NBR,   1, 5, 0, 1, 0, 0, 0),       1, none},
            '{mk(pse_pkg::CMD_NBR,   1, 2, 255, 1, 0, 0, 0),     1, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 0, 255, 0),     0, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 17, 17, 0),     0, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 17, 100, 0),    0, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 17, 200, 511),  0, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 101, 102, 0),   1, skipped},
            '{mk(pse_pkg::CMD_NBR,   1, 5, 0, 0, 0, 0, 0),       1, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 255, 0, 1),     0, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 0, 200, 511),   0, none},
            '{mk(pse_pkg::CMD_PLACE, 2, 0, 0, 0, 0, 0, 0),       1, none},
            '{mk(pse_pkg::CMD_SWAP,  0, 0, 0, 0, 0, 255, 0),     0, none}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_grid_side(pse_pkg::GRID_SIDE_RESET);

        foreach (vectors[i])
        begin
            issue(vectors[i].it, vectors[i].typed, vectors[i].res);
            idle_gap();
        end

        // Extremes first, then out-of-range values that the block clamps, then a random side in range.
        sides = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd1, 5'($urandom_range(3, 15))};
        foreach (sides[p])
        begin
            drain();
            write_grid_side(sides[p]);
            for (int n = 0; n < 200; n++)
            begin
                if (p == 0 && n == 100)
                    drain();
                issue(random_command(), 0, none);
                idle_gap();
            end
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d result beats: %0d loads, %0d swaps accepted, %0d rejected,",
                 n_results, n_loads, n_accepted, n_rejected);
        $display("%0d skipped, over six grid side settings.", n_skipped);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: placement_swap_evaluator_top.f
+incdir+rtl
rtl/pse_pkg.sv
rtl/pse_ram.sv
rtl/pse_divmod.sv
rtl/placement_swap_evaluator_top.sv
rtl/pse_checker.sv
test/placement_swap_evaluator_top_test.sv
